### sv/u2l_pkg.sv
// Package for the UTF-8 to 8-bit character decoder.
// Holds the decoder state, the result item and pair types, error codes and queue sizes.
// No dependencies; every other file of the block imports it.
`default_nettype none

package u2l_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] QMARK = 8'h3F;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_STRAY      = 3'd1;
    localparam logic [2:0] ERR_BAD_LEAD   = 3'd2;
    localparam logic [2:0] ERR_INCOMPLETE = 3'd3;
    localparam logic [2:0] ERR_OVERLONG   = 3'd4;
    localparam logic [2:0] ERR_NONCHAR    = 3'd5;

    typedef struct packed {
        logic [30:0] code_accum;
        logic [2:0]  bytes_due;
        logic [2:0]  seq_length;
    } u2l_state_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic [2:0] error_kind;
        logic       last_of_run;
        logic       text_done;
    } u2l_result_t;

    typedef struct packed {
        u2l_result_t res1;
        u2l_result_t res0;
        logic [1:0]  count;
    } u2l_pair_t;

endpackage

`default_nettype wire

### sv/u2l_decode.sv
// Combinational decode step: one input byte against the current decoder state.
// Produces the next state and zero, one or two result items. Depends on u2l_pkg.
`default_nettype none

module u2l_decode
    import u2l_pkg::*;
(
    input  wire logic [7:0] byte_in,
    input  wire logic       end_of_text,
    input  wire u2l_state_t state,
    output u2l_state_t      state_next,
    output u2l_pair_t       results
);

    logic        is_cont;
    logic [30:0] acc_shift;
    logic [2:0]  due_dec;
    logic        too_small;
    logic [7:0]  fin_char;
    logic [2:0]  fin_err;

    always_comb
    begin
        is_cont   = (byte_in[7:6] == 2'b10);
        acc_shift = {state.code_accum[24:0], byte_in[5:0]};
        due_dec   = state.bytes_due - 3'd1;

        unique case (state.seq_length)
            3'd2:    too_small = (acc_shift[30:7] == '0) && (acc_shift != '0);
            3'd3:    too_small = (acc_shift[30:11] == '0);
            3'd4:    too_small = (acc_shift[30:16] == '0);
            3'd5:    too_small = (acc_shift[30:21] == '0);
            3'd6:    too_small = (acc_shift[30:26] == '0);
            default: too_small = 1'b0;
        endcase

        if (too_small)
        begin
            fin_char = QMARK;
            fin_err  = ERR_OVERLONG;
        end
        else if (acc_shift == 31'h0000FFFE || acc_shift == 31'h0000FFFF)
        begin
            fin_char = QMARK;
            fin_err  = ERR_NONCHAR;
        end
        else if (acc_shift[30:8] != '0)
        begin
            fin_char = QMARK;
            fin_err  = ERR_NONE;
        end
        else
        begin
            fin_char = acc_shift[7:0];
            fin_err  = ERR_NONE;
        end
    end

    u2l_result_t res [2];
    logic [1:0]  cnt;
    u2l_state_t  st;

    always_comb
    begin
        res[0] = '0;
        res[1] = '0;
        cnt    = 2'd0;
        st     = state;

        if (state.bytes_due != 3'd0 && is_cont)
        begin
            st.code_accum = acc_shift;
            st.bytes_due  = due_dec;
            if (due_dec == 3'd0)
            begin
                res[cnt[0]] = '{char_out: fin_char, error_kind: fin_err,
                                last_of_run: 1'b0, text_done: 1'b0};
                cnt = cnt + 2'd1;
                st  = '0;
            end
        end
        else
        begin
            if (state.bytes_due != 3'd0)
            begin
                res[cnt[0]] = '{char_out: QMARK, error_kind: ERR_INCOMPLETE,
                                last_of_run: 1'b0, text_done: 1'b0};
                cnt = cnt + 2'd1;
                st  = '0;
            end
            priority casez (byte_in)
                8'b10??????:
                begin
                    res[cnt[0]] = '{char_out: QMARK, error_kind: ERR_STRAY,
                                    last_of_run: 1'b0, text_done: 1'b0};
                    cnt = cnt + 2'd1;
                end
                8'b110?????:
                begin
                    st = '{code_accum: 31'(byte_in[4:0]), bytes_due: 3'd1, seq_length: 3'd2};
                end
                8'b1110????:
                begin
                    st = '{code_accum: 31'(byte_in[3:0]), bytes_due: 3'd2, seq_length: 3'd3};
                end
                8'b11110???:
                begin
                    st = '{code_accum: 31'(byte_in[2:0]), bytes_due: 3'd3, seq_length: 3'd4};
                end
                8'b111110??:
                begin
                    st = '{code_accum: 31'(byte_in[1:0]), bytes_due: 3'd4, seq_length: 3'd5};
                end
                8'b1111110?:
                begin
                    st = '{code_accum: 31'(byte_in[0]), bytes_due: 3'd5, seq_length: 3'd6};
                end
                8'b1111111?:
                begin
                    res[cnt[0]] = '{char_out: QMARK, error_kind: ERR_BAD_LEAD,
                                    last_of_run: 1'b0, text_done: 1'b0};
                    cnt = cnt + 2'd1;
                end
                default:
                begin
                    res[cnt[0]] = '{char_out: byte_in, error_kind: ERR_NONE,
                                    last_of_run: 1'b0, text_done: 1'b0};
                    cnt = cnt + 2'd1;
                end
            endcase
        end

        if (end_of_text && st.bytes_due != 3'd0)
        begin
            res[cnt[0]] = '{char_out: QMARK, error_kind: ERR_INCOMPLETE,
                            last_of_run: 1'b0, text_done: 1'b0};
            cnt = cnt + 2'd1;
            st  = '0;
        end

        if (cnt != 2'd0)
        begin
            res[cnt[1]].last_of_run = 1'b1;
            res[cnt[1]].text_done   = end_of_text;
        end
    end

    assign state_next = st;
    assign results    = '{res1: res[1], res0: res[0], count: cnt};

endmodule

`default_nettype wire

### sv/u2l_result_queue.sv
// Small result queue that takes up to two result items per cycle and hands out one.
// Its fill level sets the input stall. Depends on u2l_pkg.
`default_nettype none

module u2l_result_queue
    import u2l_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire u2l_pair_t push,
    output logic           full,
    output logic           out_valid,
    input  wire logic      out_stall,
    output u2l_result_t    out_item
);

    u2l_result_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] head_reg;
    logic [QPTR_W-1:0] head_next;
    logic [QPTR_W-1:0] tail_reg;
    logic [QPTR_W-1:0] tail_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              pop;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[head_reg];
    assign full      = (count_reg > QCNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        head_next  = head_reg + QPTR_W'(pop);
        tail_next  = tail_reg + QPTR_W'(push.count);
        count_next = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[tail_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[tail_reg + QPTR_W'(1)] <= push.res1;
        end
    end

endmodule

`default_nettype wire

### sv/utf8_to_latin1_decoder.sv
// Top level of the UTF-8 to 8-bit character decoder.
// Instantiates u2l_decode and u2l_result_queue; depends on u2l_pkg.
//
// The block takes one byte of UTF-8 text per item and returns 8-bit characters: code
// points below 0x100 pass through, all others and malformed input come out as '?' with
// an error code. An input byte can be taken in every cycle in which in_stall is low; its
// results are registered in the result queue and appear in the cycle after acceptance
// at the earliest, at most one result item per cycle. Each byte gives zero, one or two
// results, which wait in a four-entry result queue; the input stalls while that queue
// holds more than two results.
`default_nettype none

module utf8_to_latin1_decoder
    import u2l_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] byte_in,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      char_out,
    output logic [2:0]      error_kind,
    output logic            last_of_run,
    output logic            text_done
);

    u2l_state_t  state_reg;
    u2l_state_t  state_next;
    u2l_pair_t   step_results;
    u2l_pair_t   push;
    u2l_result_t head_item;
    logic        queue_full;
    logic        accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    u2l_decode u_decode (
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .state       (state_reg),
        .state_next  (state_next),
        .results     (step_results)
    );

    always_comb
    begin
        push = step_results;
        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    u2l_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (head_item)
    );

    assign char_out    = head_item.char_out;
    assign error_kind  = head_item.error_kind;
    assign last_of_run = head_item.last_of_run;
    assign text_done   = head_item.text_done;

endmodule

`default_nettype wire
